// ===== sv/cbe_pkg.sv =====
package cbe_pkg;

  localparam int unsigned NewtonStepsDef = 8;
  localparam int unsigned BisectStepsDef = 24;

  localparam int unsigned FieldW = 19;
  localparam int unsigned CtrlXW = 17;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 19;

  localparam int unsigned TW = 31;
  localparam int unsigned OpW = 34;
  localparam int unsigned PrdW = 37;
  localparam int unsigned AccW = 40;
  localparam int unsigned DvdW = 62;
  localparam int unsigned DvsW = 36;

  localparam logic [TW-1:0] QOneT = TW'(1073741824);
  localparam logic signed [AccW-1:0] QOne = AccW'(1073741824);
  localparam logic signed [AccW-1:0] QTol = AccW'(1074);

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE = 3'd0,
    REG_X1   = 3'd1,
    REG_Y1   = 3'd2,
    REG_X2   = 3'd3,
    REG_Y2   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic go;
    logic done;
  } div_ctl_t;

endpackage

// ===== sv/cbe_mul.sv =====
module cbe_mul (
  input  logic                             clk_i,
  input  logic signed [cbe_pkg::OpW-1:0]   a_i,
  input  logic signed [cbe_pkg::OpW-1:0]   b_i,
  output logic signed [cbe_pkg::PrdW-1:0]  prod_o
);

  logic [cbe_pkg::OpW-2:0]     mag_a, mag_b;
  logic [2*cbe_pkg::OpW-3:0]   full;
  logic [cbe_pkg::PrdW-1:0]    shr;
  logic signed [cbe_pkg::PrdW-1:0] prod_d, prod_q;

  always_comb begin
    mag_a = a_i[cbe_pkg::OpW-1] ? (cbe_pkg::OpW-1)'(-a_i) : a_i[cbe_pkg::OpW-2:0];
    mag_b = b_i[cbe_pkg::OpW-1] ? (cbe_pkg::OpW-1)'(-b_i) : b_i[cbe_pkg::OpW-2:0];
    full  = mag_a * mag_b;
    shr   = {1'b0, full[2*cbe_pkg::OpW-3:30]};
    prod_d = (a_i[cbe_pkg::OpW-1] ^ b_i[cbe_pkg::OpW-1]) ? -$signed(shr) : $signed(shr);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ===== sv/cbe_div.sv =====
module cbe_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cbe_pkg::div_ctl_t             ctl_i,
  output cbe_pkg::div_ctl_t             ctl_o,
  input  logic [cbe_pkg::DvdW-1:0]      dividend_i,
  input  logic [cbe_pkg::DvsW-1:0]      divisor_i,
  output logic [cbe_pkg::DvdW-1:0]      quotient_o
);

  localparam int unsigned CntW = $clog2(cbe_pkg::DvdW + 1);

  logic [cbe_pkg::DvsW-1:0] rem_q, dvs_q;
  logic [cbe_pkg::DvdW-1:0] quo_q;
  logic [CntW-1:0]          cnt_q;
  logic                     run_q, done_q;
  logic [cbe_pkg::DvsW:0]   shifted, diff;
  logic                     fit;

  always_comb begin
    shifted = {rem_q, quo_q[cbe_pkg::DvdW-1]};
    diff    = shifted - {1'b0, dvs_q};
    fit     = shifted >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.go) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == CntW'(cbe_pkg::DvdW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.go) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= fit ? diff[cbe_pkg::DvsW-1:0] : shifted[cbe_pkg::DvsW-1:0];
      quo_q <= {quo_q[cbe_pkg::DvdW-2:0], fit};
    end
  end

  assign ctl_o.go   = run_q;
  assign ctl_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== sv/cubic_bezier_easing_eval_unit.sv =====
// Cubic Bezier easing evaluator. Pulse start while busy is low to hand
// over one progress value; busy stays high until the result appears on
// eased_value_o for exactly one cycle with valid_o high, and the receiver
// must take it then. Mode 1 runs on one shared 33x33 multiplier: each step
// evaluates the curve, Newton steps also take a slope and a quotient from a
// radix-2 divider, and bisection takes over when Newton runs out of steps or
// meets a flat slope; an item finishes early when Newton or bisection
// converges. The endpoints of mode 1 skip the search and go straight to the
// output state. Configuration is always ready and must only be written
// while busy is low.
module cubic_bezier_easing_eval_unit #(
  parameter int unsigned NEWTON_STEPS = cbe_pkg::NewtonStepsDef,
  parameter int unsigned BISECT_STEPS = cbe_pkg::BisectStepsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [cbe_pkg::FieldW-1:0]  progress_i,
  output logic                               valid_o,
  output logic signed [cbe_pkg::FieldW-1:0]  eased_value_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cbe_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [cbe_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned NW = $clog2(NEWTON_STEPS + 1);
  localparam int unsigned BW = $clog2(BISECT_STEPS + 1);
  localparam int unsigned OpW = cbe_pkg::OpW;
  localparam int unsigned AccW = cbe_pkg::AccW;
  localparam int unsigned TW = cbe_pkg::TW;

  typedef enum logic [2:0] {
    S_IDLE, S_M0, S_CURVE, S_SLOPE, S_DIV, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    K_NEWTON, K_BISECT, K_FINAL
  } kind_e;

  state_e state_q;
  kind_e  kind_q;
  logic [3:0] k_q;
  logic [NW-1:0] n_q;
  logic [BW-1:0] b_q;
  logic ysel_q, neg_q, go_q, valid_q;

  logic mode_q;
  logic [cbe_pkg::CtrlXW-1:0] x1_q, x2_q;
  logic [cbe_pkg::FieldW-1:0] y1_q, y2_q;

  logic [TW-1:0] t_q, p_q, lo_q, hi_q, u;
  logic signed [AccW-1:0] acc_q, ttt_q, err_q;
  logic signed [cbe_pkg::PrdW-1:0] uut_q, utt_q, uu_q, ut_q, tt_q;
  logic signed [cbe_pkg::FieldW-1:0] res_q;

  logic signed [OpW-1:0] ma, mb, ca, cb, t_op, u_op;
  logic signed [cbe_pkg::PrdW-1:0] prod;
  logic signed [AccW-1:0] prod_x, prod3, cv, diff, dv;
  logic [TW-1:0] x1_30, x2_30, mid_lo, mid_hi;
  logic [cbe_pkg::CtrlXW-1:0] x1c, x2c;
  logic [cbe_pkg::FieldW-1:0] pc;
  logic [TW:0] mid_sum;
  logic [cbe_pkg::DvdW-1:0] quo;
  logic [cbe_pkg::DvdW:0] t_add;
  logic [TW-1:0] t_new;
  logic [AccW-1:0] err_mag, d_mag;
  cbe_pkg::div_ctl_t div_in, div_out;

  function automatic logic signed [cbe_pkg::FieldW-1:0] to_port(
    input logic signed [AccW-1:0] v
  );
    logic [AccW-1:0] mg;
    logic [AccW-1:0] rm;
    logic signed [AccW-1:0] r;
    mg = v[AccW-1] ? AccW'(-v) : v;
    rm = (mg + AccW'(8192)) >> 14;
    r  = v[AccW-1] ? -$signed(rm) : $signed(rm);
    if (r < -AccW'(131072)) r = -AccW'(131072);
    if (r > AccW'(196608)) r = AccW'(196608);
    return r[cbe_pkg::FieldW-1:0];
  endfunction

  function automatic logic is_tiny(input logic signed [AccW-1:0] v);
    return (v < cbe_pkg::QTol) && (v > -cbe_pkg::QTol);
  endfunction

  // control points in Q30
  always_comb begin
    x1c   = (x1_q > cbe_pkg::CtrlXW'(65536)) ? cbe_pkg::CtrlXW'(65536) : x1_q;
    x2c   = (x2_q > cbe_pkg::CtrlXW'(65536)) ? cbe_pkg::CtrlXW'(65536) : x2_q;
    x1_30 = {x1c, 14'b0};
    x2_30 = {x2c, 14'b0};
    ca    = ysel_q ? OpW'($signed({y1_q, 14'b0})) : $signed({3'b0, x1_30});
    cb    = ysel_q ? OpW'($signed({y2_q, 14'b0})) : $signed({3'b0, x2_30});
    u     = cbe_pkg::QOneT - t_q;
    t_op  = $signed({3'b0, t_q});
    u_op  = $signed({3'b0, u});
  end

  // shared multiplier operand select
  always_comb begin
    ma = u_op;
    mb = u_op;
    case (state_q)
      S_M0: begin
        if (k_q == 4'd1) begin
          ma = OpW'(prod);
        end
      end
      S_CURVE: begin
        case (k_q)
          4'd1: begin ma = OpW'(prod); mb = t_op; end
          4'd2: begin ma = u_op; mb = t_op; end
          4'd3: begin ma = OpW'(prod); mb = t_op; end
          4'd4: begin ma = t_op; mb = t_op; end
          4'd5: begin ma = OpW'(prod); mb = t_op; end
          4'd6: begin ma = OpW'(uut_q); mb = ca; end
          4'd7: begin ma = OpW'(utt_q); mb = cb; end
          default: begin ma = u_op; mb = u_op; end
        endcase
      end
      S_SLOPE: begin
        case (k_q)
          4'd0: begin ma = OpW'(uu_q); mb = ca; end
          4'd1: begin
            ma = OpW'(ut_q);
            mb = $signed({3'b0, x2_30}) - $signed({3'b0, x1_30});
          end
          default: begin
            ma = OpW'(tt_q);
            mb = $signed({3'b0, cbe_pkg::QOneT - x2_30});
          end
        endcase
      end
      default: begin
        ma = u_op;
        mb = u_op;
      end
    endcase
  end

  cbe_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (ma),
    .b_i    (mb),
    .prod_o (prod)
  );

  always_comb begin
    prod_x  = AccW'(prod);
    prod3   = (prod_x <<< 1) + prod_x;
    cv      = acc_q + prod3 + ttt_q;
    diff    = cv - $signed({9'b0, p_q});
    dv      = acc_q + prod3;
    err_mag = err_q[AccW-1] ? AccW'(-err_q) : err_q;
    d_mag   = dv[AccW-1] ? AccW'(-dv) : dv;
    mid_lo  = diff[AccW-1] ? t_q : lo_q;
    mid_hi  = diff[AccW-1] ? hi_q : t_q;
    mid_sum = {1'b0, mid_lo} + {1'b0, mid_hi};
    pc      = progress_i[cbe_pkg::FieldW-1] ? '0 :
              (progress_i > cbe_pkg::FieldW'(65536)) ? cbe_pkg::FieldW'(65536) :
              progress_i;
    t_add   = {1'b0, quo} + (cbe_pkg::DvdW + 1)'(t_q);
    if (neg_q) begin
      t_new = (t_add > (cbe_pkg::DvdW + 1)'(cbe_pkg::QOneT)) ? cbe_pkg::QOneT : t_add[TW-1:0];
    end else begin
      t_new = (quo > cbe_pkg::DvdW'(t_q)) ? '0 : t_q - quo[TW-1:0];
    end
  end

  assign div_in.go   = go_q;
  assign div_in.done = 1'b0;

  cbe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_in),
    .ctl_o      (div_out),
    .dividend_i ({err_mag[31:0], 30'b0}),
    .divisor_i  (d_mag[cbe_pkg::DvsW-1:0]),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      x1_q   <= cbe_pkg::CtrlXW'(3277);
      y1_q   <= cbe_pkg::FieldW'(45875);
      x2_q   <= cbe_pkg::CtrlXW'(6554);
      y2_q   <= cbe_pkg::FieldW'(65536);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cbe_pkg::REG_MODE: mode_q <= cfg_data_i[0];
        cbe_pkg::REG_X1:   x1_q   <= cfg_data_i[cbe_pkg::CtrlXW-1:0];
        cbe_pkg::REG_Y1:   y1_q   <= cfg_data_i;
        cbe_pkg::REG_X2:   x2_q   <= cfg_data_i[cbe_pkg::CtrlXW-1:0];
        cbe_pkg::REG_Y2:   y2_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= K_NEWTON;
      k_q     <= '0;
      n_q     <= '0;
      b_q     <= '0;
      ysel_q  <= 1'b0;
      neg_q   <= 1'b0;
      go_q    <= 1'b0;
      valid_q <= 1'b0;
      t_q     <= '0;
      p_q     <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      acc_q   <= '0;
      ttt_q   <= '0;
      err_q   <= '0;
      uut_q   <= '0;
      utt_q   <= '0;
      uu_q    <= '0;
      ut_q    <= '0;
      tt_q    <= '0;
      res_q   <= '0;
    end else begin
      valid_q <= 1'b0;
      go_q    <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            p_q    <= {pc[16:0], 14'b0};
            t_q    <= {pc[16:0], 14'b0};
            k_q    <= '0;
            n_q    <= '0;
            ysel_q <= 1'b0;
            kind_q <= K_NEWTON;
            if (!mode_q) begin
              state_q <= S_M0;
            end else if (pc == '0) begin
              acc_q   <= '0;
              state_q <= S_OUT;
            end else if (pc == cbe_pkg::FieldW'(65536)) begin
              acc_q   <= cbe_pkg::QOne;
              state_q <= S_OUT;
            end else begin
              state_q <= S_CURVE;
            end
          end
        end
        S_M0: begin
          k_q <= k_q + 1'b1;
          if (k_q == 4'd2) begin
            acc_q   <= cbe_pkg::QOne - prod_x;
            state_q <= S_OUT;
          end
        end
        S_CURVE: begin
          k_q <= k_q + 1'b1;
          case (k_q)
            4'd1: uu_q  <= prod;
            4'd2: uut_q <= prod;
            4'd3: ut_q  <= prod;
            4'd4: utt_q <= prod;
            4'd5: tt_q  <= prod;
            4'd6: ttt_q <= AccW'(prod);
            4'd7: acc_q <= prod3;
            4'd8: begin
              k_q <= '0;
              case (kind_q)
                K_NEWTON: begin
                  if (is_tiny(diff)) begin
                    kind_q <= K_FINAL;
                    ysel_q <= 1'b1;
                  end else begin
                    err_q   <= diff;
                    state_q <= S_SLOPE;
                  end
                end
                K_BISECT: begin
                  if (is_tiny(diff)) begin
                    kind_q <= K_FINAL;
                    ysel_q <= 1'b1;
                  end else begin
                    lo_q <= mid_lo;
                    hi_q <= mid_hi;
                    t_q  <= mid_sum[TW:1];
                    b_q  <= b_q + 1'b1;
                    if (b_q == BW'(BISECT_STEPS - 1)) begin
                      kind_q <= K_FINAL;
                      ysel_q <= 1'b1;
                    end
                  end
                end
                default: begin
                  acc_q   <= cv;
                  state_q <= S_OUT;
                end
              endcase
            end
            default: ;
          endcase
        end
        S_SLOPE: begin
          k_q <= k_q + 1'b1;
          case (k_q)
            4'd1: acc_q <= prod3;
            4'd2: acc_q <= acc_q + (prod_x <<< 1) + (prod_x <<< 2);
            4'd3: begin
              k_q <= '0;
              if (is_tiny(dv)) begin
                t_q     <= p_q;
                lo_q    <= '0;
                hi_q    <= cbe_pkg::QOneT;
                b_q     <= '0;
                kind_q  <= K_BISECT;
                state_q <= S_CURVE;
              end else begin
                neg_q   <= err_q[AccW-1] ^ dv[AccW-1];
                go_q    <= 1'b1;
                state_q <= S_DIV;
              end
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (div_out.done) begin
            k_q     <= '0;
            state_q <= S_CURVE;
            if (n_q == NW'(NEWTON_STEPS - 1)) begin
              t_q    <= p_q;
              lo_q   <= '0;
              hi_q   <= cbe_pkg::QOneT;
              b_q    <= '0;
              kind_q <= K_BISECT;
            end else begin
              t_q <= t_new;
              n_q <= n_q + 1'b1;
            end
          end
        end
        S_OUT: begin
          res_q   <= to_port(acc_q);
          valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign valid_o       = valid_q;
  assign eased_value_o = res_q;
  assign cfg_ready_o   = 1'b1;

  a_valid_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("result without a running item");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("transfer did not start the sequencer");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held for more than one cycle");

  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (t_q <= cbe_pkg::QOneT))
    else $error("curve parameter out of range");

  a_bracket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CURVE && kind_q == K_BISECT) |-> (lo_q <= hi_q))
    else $error("bisection bracket inverted");

endmodule
